// ----- sv/trm_pkg.sv -----
`timescale 1ns / 1ps
package trm_pkg;

    // Instruction codes; code seven is not assigned and executes as a no-op.
    typedef enum logic [2:0] {
        OP_SET = 3'd0,
        OP_SND = 3'd1,
        OP_RCV = 3'd2,
        OP_ADD = 3'd3,
        OP_MUL = 3'd4,
        OP_MOD = 3'd5,
        OP_JGZ = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MD,
        S_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_mode;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned PC_W   = 32;
    localparam int unsigned IMM_W  = 32;
    localparam int unsigned IDX_W  = 5;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic start_mul;
        logic start_div;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    x_is_reg;
        logic    y_zero;
        logic    md_done;
        logic    out_free;
    } t_sts;

endpackage

// ----- sv/trm_muldiv.sv -----
`timescale 1ns / 1ps
module trm_muldiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start_mul,
    input  logic                      i_start_div,
    input  logic [trm_pkg::DATA_W-1:0] i_a,
    input  logic [trm_pkg::DATA_W-1:0] i_b,
    output logic                      o_done,
    output logic [trm_pkg::DATA_W-1:0] o_result
);
    import trm_pkg::*;

    t_md_mode          r_mode, n_mode;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_a, r_b, r_acc, r_rem;
    logic              r_neg, r_is_div;

    logic [31:0]       w_ma, w_mb;
    logic [DATA_W-1:0] w_prod, w_term;
    logic [DATA_W-1:0] w_t, w_rem_n;

    // The low 64 bits of the product need three 32x32 partial products;
    // the high-by-high term falls entirely above bit 63.
    always_comb begin
        case (r_cnt)
            6'd0: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            6'd1: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
            default: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
        endcase
        w_prod = DATA_W'(w_ma) * DATA_W'(w_mb);
        w_term = (r_cnt == 6'd0) ? w_prod : {w_prod[31:0], 32'd0};
    end

    // One restoring step on magnitudes; the remainder stays below the divisor,
    // so the shifted value still fits in 64 bits.
    always_comb begin
        w_t     = {r_rem[DATA_W-2:0], r_a[DATA_W-1]};
        w_rem_n = (w_t >= r_b) ? (w_t - r_b) : w_t;
    end

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        case (r_mode)
            MD_IDLE: begin
                if (i_start_mul) begin
                    n_mode = MD_MUL;
                    n_cnt  = 6'd0;
                end else if (i_start_div) begin
                    n_mode = MD_DIV;
                    n_cnt  = 6'd63;
                end
            end
            MD_MUL: begin
                if (r_cnt == 6'd2) begin
                    n_mode = MD_IDLE;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            MD_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_mode = MD_IDLE;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: begin
                n_mode = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE;
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mode == MD_IDLE && i_start_mul) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_acc    <= '0;
            r_is_div <= 1'b0;
        end else if (r_mode == MD_IDLE && i_start_div) begin
            r_a      <= i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
            r_b      <= i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
            r_rem    <= '0;
            r_neg    <= i_a[DATA_W-1];
            r_is_div <= 1'b1;
        end else if (r_mode == MD_MUL) begin
            r_acc <= r_acc + w_term;
        end else if (r_mode == MD_DIV) begin
            r_rem <= w_rem_n;
            r_a   <= {r_a[DATA_W-2:0], 1'b0};
        end
    end

    // The remainder takes the sign of the dividend.
    assign o_result = r_is_div ? (r_neg ? (DATA_W'(0) - r_rem) : r_rem) : r_acc;
    assign o_done   = r_done;

endmodule

// ----- sv/trm_dpath.sv -----
`timescale 1ns / 1ps
module trm_dpath #(
    parameter int NUM_REGS = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  trm_pkg::t_cmd               i_cmd,
    output trm_pkg::t_sts               o_sts,
    input  logic [2:0]                  i_opcode,
    input  logic                        i_x_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]   i_x_reg,
    input  logic signed [trm_pkg::IMM_W-1:0] i_x_imm,
    input  logic                        i_y_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]   i_y_reg,
    input  logic signed [trm_pkg::IMM_W-1:0] i_y_imm,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic signed [trm_pkg::PC_W-1:0]   o_next_pc,
    output logic signed [trm_pkg::DATA_W-1:0] o_last_sound,
    output logic                        o_recovered
);
    import trm_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Captured instruction.
    logic [2:0]       r_op;
    logic             r_x_is_reg, r_y_is_reg;
    logic [IDX_W-1:0] r_x_reg, r_y_reg;
    logic [IMM_W-1:0] r_x_imm, r_y_imm;

    logic [DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [DATA_W-1:0] r_rd_x, r_rd_y;
    logic              r_x_ok, r_y_ok;

    logic [PC_W-1:0]   r_pc;
    logic [DATA_W-1:0] r_sound;

    logic              r_out_valid;
    logic [PC_W-1:0]   r_out_pc;
    logic [DATA_W-1:0] r_out_sound;
    logic              r_out_rec;

    logic [6:0]        w_x_ext, w_y_ext;
    logic              w_x_in, w_y_in;
    logic [AW-1:0]     w_x_addr, w_y_addr;
    logic [DATA_W-1:0] w_xv, w_yv;
    logic              w_x_pos, w_x_nz;
    t_opcode           w_op;
    logic              w_md_done;
    logic [DATA_W-1:0] w_md_res;
    logic              w_wb_en;
    logic [DATA_W-1:0] w_wb;
    logic [PC_W-1:0]   w_pc_n;
    logic              w_rec;

    assign w_op = t_opcode'(r_op);

    // Indices at or beyond the register count read as zero and drop writes.
    assign w_x_ext  = {2'b00, r_x_reg};
    assign w_y_ext  = {2'b00, r_y_reg};
    assign w_x_in   = w_x_ext < 7'(NUM_REGS);
    assign w_y_in   = w_y_ext < 7'(NUM_REGS);
    assign w_x_addr = w_x_ext[AW-1:0];
    assign w_y_addr = w_y_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_x_is_reg <= i_x_is_reg;
            r_x_reg    <= i_x_reg;
            r_x_imm    <= i_x_imm;
            r_y_is_reg <= i_y_is_reg;
            r_y_reg    <= i_y_reg;
            r_y_imm    <= i_y_imm;
        end
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem[w_x_addr];
            r_rd_y <= r_mem[w_y_addr];
        end
        if (w_wb_en) begin
            r_mem[w_x_addr] <= w_wb;
        end
    end

    // An entry not yet written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_x_ok <= 1'b0;
            r_y_ok <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_x_ok <= w_x_in && r_vld[w_x_addr];
                r_y_ok <= w_y_in && r_vld[w_y_addr];
            end
            if (w_wb_en) begin
                r_vld[w_x_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_x_is_reg) begin
            w_xv = r_x_ok ? r_rd_x : '0;
        end else begin
            w_xv = {{(DATA_W-IMM_W){r_x_imm[IMM_W-1]}}, r_x_imm};
        end
        if (r_y_is_reg) begin
            w_yv = r_y_ok ? r_rd_y : '0;
        end else begin
            w_yv = {{(DATA_W-IMM_W){r_y_imm[IMM_W-1]}}, r_y_imm};
        end
    end

    assign w_x_nz  = |w_xv;
    assign w_x_pos = w_x_nz && !w_xv[DATA_W-1];

    trm_muldiv u_md (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_mul (i_cmd.start_mul),
        .i_start_div (i_cmd.start_div),
        .i_a         (w_xv),
        .i_b         (w_yv),
        .o_done      (w_md_done),
        .o_result    (w_md_res)
    );

    always_comb begin
        w_wb    = w_yv;
        w_wb_en = 1'b0;
        w_pc_n  = r_pc + 32'd1;
        w_rec   = 1'b0;
        case (w_op)
            OP_SET: begin
                w_wb_en = 1'b1;
            end
            OP_ADD: begin
                w_wb    = w_xv + w_yv;
                w_wb_en = 1'b1;
            end
            OP_MUL: begin
                w_wb    = w_md_res;
                w_wb_en = 1'b1;
            end
            OP_MOD: begin
                w_wb    = w_md_res;
                w_wb_en = |w_yv;
            end
            OP_RCV: begin
                if (w_x_nz) begin
                    w_rec  = 1'b1;
                    w_pc_n = r_pc;
                end
            end
            OP_JGZ: begin
                if (w_x_pos) begin
                    w_pc_n = r_pc + w_yv[PC_W-1:0];
                end
            end
            default: begin
            end
        endcase
        w_wb_en = w_wb_en && r_x_is_reg && w_x_in && i_cmd.commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_sound     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pc        <= w_pc_n;
                r_out_valid <= 1'b1;
                if (w_op == OP_SND) begin
                    r_sound <= w_xv;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_pc    <= w_pc_n;
            r_out_sound <= (w_op == OP_SND) ? w_xv : r_sound;
            r_out_rec   <= w_rec;
        end
    end

    always_comb begin
        o_sts.op       = w_op;
        o_sts.x_is_reg = r_x_is_reg;
        o_sts.y_zero   = ~|w_yv;
        o_sts.md_done  = w_md_done;
        o_sts.out_free = !r_out_valid || i_ready;
    end

    assign o_valid      = r_out_valid;
    assign o_next_pc    = r_out_pc;
    assign o_last_sound = r_out_sound;
    assign o_recovered  = r_out_rec;

endmodule

// ----- sv/trm_ctrl.sv -----
`timescale 1ns / 1ps
module trm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  trm_pkg::t_sts i_sts,
    output logic          o_ready,
    output trm_pkg::t_cmd o_cmd
);
    import trm_pkg::*;

    t_state r_state, n_state;
    logic   w_need_md;

    // Multiply and remainder go to the iterative unit only when they write
    // a register; remainder by zero leaves the register alone.
    assign w_need_md = i_sts.x_is_reg &&
                       ((i_sts.op == OP_MUL) || (i_sts.op == OP_MOD && !i_sts.y_zero));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = w_need_md ? S_MD : S_COMMIT;
            end
            S_MD: begin
                if (i_sts.md_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.start_mul = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_EXEC: begin
                o_cmd.start_mul = w_need_md && (i_sts.op == OP_MUL);
                o_cmd.start_div = w_need_md && (i_sts.op == OP_MOD);
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/tiny_register_machine_execute_unit.sv -----
`timescale 1ns / 1ps
// Executes one decoded set/snd/rcv/add/mul/mod/jgz instruction per item against
// NUM_REGS signed 64-bit registers, a 32-bit pc and a sound latch, and returns one
// result item (next pc, sound latch, recovery flag) per instruction. Items are
// handled one at a time: most instructions pass through accept, register file
// read, execute and commit; mul with a register destination adds a multiply step,
// since the shared 32x32 multiplier builds the low 64 bits from three partial
// products; mod with a register destination and nonzero divisor adds the
// one-bit-per-cycle remainder loop. A finished result waits in an output register,
// so the next item is accepted while it is still pending. Registers read as zero
// until first written after reset; there is no clearing pass.
module tiny_register_machine_execute_unit #(
    parameter int NUM_REGS = 26
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_opcode,
    input  logic                              i_x_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]         i_x_reg,
    input  logic signed [trm_pkg::IMM_W-1:0]  i_x_imm,
    input  logic                              i_y_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]         i_y_reg,
    input  logic signed [trm_pkg::IMM_W-1:0]  i_y_imm,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [trm_pkg::PC_W-1:0]   o_next_pc,
    output logic signed [trm_pkg::DATA_W-1:0] o_last_sound,
    output logic                              o_recovered
);
    import trm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    trm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    trm_dpath #(
        .NUM_REGS (NUM_REGS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_opcode     (i_opcode),
        .i_x_is_reg   (i_x_is_reg),
        .i_x_reg      (i_x_reg),
        .i_x_imm      (i_x_imm),
        .i_y_is_reg   (i_y_is_reg),
        .i_y_reg      (i_y_reg),
        .i_y_imm      (i_y_imm),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_next_pc    (o_next_pc),
        .o_last_sound (o_last_sound),
        .o_recovered  (o_recovered)
    );

`ifndef SYNTHESIS
    // An accepted item blocks further input until it has been committed.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_ready)
        else $error("input ready while an item is in progress");

    // A commit never overwrites a result that has not been taken.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_valid || i_ready))
        else $error("commit into an occupied output register");

    // Every commit presents a result item on the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("committed item not presented");
`endif

endmodule

// ----- dv/trm_execute_checker.sv -----
`timescale 1ns / 1ps
module trm_execute_checker #(
    parameter int NUM_REGS = 26
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [2:0]                 i_opcode,
    input  logic                       i_x_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]  i_x_reg,
    input  logic [trm_pkg::IMM_W-1:0]  i_x_imm,
    input  logic                       i_y_is_reg,
    input  logic [trm_pkg::IDX_W-1:0]  i_y_reg,
    input  logic [trm_pkg::IMM_W-1:0]  i_y_imm,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [trm_pkg::PC_W-1:0]   i_next_pc,
    input  logic [trm_pkg::DATA_W-1:0] i_last_sound,
    input  logic                       i_recovered,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_recoveries
);
    import trm_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [DATA_W-1:0] sound;
        logic              rec;
    } t_machine_out;

    logic [DATA_W-1:0] regs_mirror [NUM_REGS];
    logic [PC_W-1:0]   pc_mirror;
    logic [DATA_W-1:0] sound_mirror;
    t_machine_out      awaited_outs [$];
    int                errors;
    int                pending;
    int                checked;
    int                recoveries;

    assign o_errors     = errors;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_recoveries = recoveries;

    task automatic flag_mismatch(input string what);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Indices past the end of the register file read as zero.
    function automatic logic [DATA_W-1:0] read_mirror(input logic [IDX_W-1:0] idx);
        if (idx >= NUM_REGS)
            return '0;
        return regs_mirror[idx];
    endfunction

    task automatic write_mirror(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        if (idx < NUM_REGS)
            regs_mirror[idx] = v;
    endtask

    function automatic logic [DATA_W-1:0] operand_value(input logic is_reg,
                                                        input logic [IDX_W-1:0] idx,
                                                        input logic [IMM_W-1:0] imm);
        if (is_reg)
            return read_mirror(idx);
        return {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
    endfunction

    // Remainder on magnitudes, so the most negative value needs no special case.
    function automatic logic [DATA_W-1:0] rem_toward_zero(input logic [DATA_W-1:0] a,
                                                          input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] r;
        ma = a[DATA_W-1] ? ('0 - a) : a;
        mb = b[DATA_W-1] ? ('0 - b) : b;
        r  = ma % mb;
        return a[DATA_W-1] ? ('0 - r) : r;
    endfunction

    task automatic execute_instr();
        logic [DATA_W-1:0] xv;
        logic [DATA_W-1:0] yv;
        logic [PC_W-1:0]   pc_n;
        logic              rec;
        t_machine_out      res;
        xv   = operand_value(i_x_is_reg, i_x_reg, i_x_imm);
        yv   = operand_value(i_y_is_reg, i_y_reg, i_y_imm);
        pc_n = pc_mirror + 1'b1;
        rec  = 1'b0;
        case (i_opcode)
            OP_SET: if (i_x_is_reg) write_mirror(i_x_reg, yv);
            OP_SND: sound_mirror = xv;
            OP_RCV: begin
                if (xv != '0) begin
                    rec  = 1'b1;
                    pc_n = pc_mirror;
                end
            end
            OP_ADD: if (i_x_is_reg) write_mirror(i_x_reg, xv + yv);
            OP_MUL: if (i_x_is_reg) write_mirror(i_x_reg, xv * yv);
            OP_MOD: begin
                if (i_x_is_reg && yv != '0)
                    write_mirror(i_x_reg, rem_toward_zero(xv, yv));
            end
            OP_JGZ: begin
                if (xv != '0 && !xv[DATA_W-1])
                    pc_n = pc_mirror + yv[PC_W-1:0];
            end
            default: ;
        endcase
        pc_mirror = pc_n;
        res.pc    = pc_n;
        res.sound = sound_mirror;
        res.rec   = rec;
        awaited_outs.insert(awaited_outs.size(), res);
    endtask

    task automatic check_result();
        t_machine_out want;
        if (awaited_outs.size() == 0) begin
            flag_mismatch($sformatf("result with no instruction outstanding (pc %0d)",
                                    $signed(i_next_pc)));
        end else begin
            want = awaited_outs.pop_front();
            if (i_next_pc !== want.pc)
                flag_mismatch($sformatf("next_pc got %0d want %0d",
                                        $signed(i_next_pc), $signed(want.pc)));
            if (i_last_sound !== want.sound)
                flag_mismatch($sformatf("last_sound got %0d want %0d",
                                        $signed(i_last_sound), $signed(want.sound)));
            if (i_recovered !== want.rec)
                flag_mismatch($sformatf("recovered got %b want %b", i_recovered, want.rec));
            if (want.rec)
                recoveries++;
            checked++;
        end
    endtask

    // Results are handled before the new instruction: a result can never
    // belong to the item accepted on the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++)
                regs_mirror[k] = '0;
            pc_mirror    = '0;
            sound_mirror = '0;
            awaited_outs.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                execute_instr();
        end
        pending = awaited_outs.size();
    end

    initial begin
        errors     = 0;
        pending    = 0;
        checked    = 0;
        recoveries = 0;
    end

endmodule

// ----- dv/tb_tiny_register_machine_execute_unit.sv -----
`timescale 1ns / 1ps
module tb_tiny_register_machine_execute_unit;
    import trm_pkg::*;

    localparam int NUM_REGS     = 26;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 80;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;

    // Unassigned opcode, executes as a no-op.
    localparam logic [2:0] OP_NOP = 3'd7;

    localparam logic [IDX_W-1:0] REG_A    = 5'd0;
    localparam logic [IDX_W-1:0] REG_B    = 5'd1;
    localparam logic [IDX_W-1:0] REG_C    = 5'd2;
    localparam logic [IDX_W-1:0] REG_D    = 5'd3;
    localparam logic [IDX_W-1:0] REG_Z    = 5'd25;
    localparam logic [IDX_W-1:0] REG_PAST = 5'd26;
    localparam logic [IDX_W-1:0] REG_TOP  = 5'd31;

    localparam logic [IMM_W-1:0] IMM_MAX  = 32'h7fff_ffff;
    localparam logic [IMM_W-1:0] IMM_MIN  = 32'h8000_0000;
    localparam logic [IMM_W-1:0] IMM_NEG1 = 32'hffff_ffff;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        opcode;
    logic              x_is_reg;
    logic [IDX_W-1:0]  x_reg;
    logic [IMM_W-1:0]  x_imm;
    logic              y_is_reg;
    logic [IDX_W-1:0]  y_reg;
    logic [IMM_W-1:0]  y_imm;
    logic              out_valid;
    logic              out_ready;
    logic [PC_W-1:0]   next_pc;
    logic [DATA_W-1:0] last_sound;
    logic              recovered;

    int   errors;
    int   pending;
    int   checked;
    int   recoveries;
    int   cycles;
    int   sent;
    int   op_count [8];
    logic calm_tail;
    logic tx_gaps;

    tiny_register_machine_execute_unit #(
        .NUM_REGS (NUM_REGS)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_opcode     (opcode),
        .i_x_is_reg   (x_is_reg),
        .i_x_reg      (x_reg),
        .i_x_imm      (x_imm),
        .i_y_is_reg   (y_is_reg),
        .i_y_reg      (y_reg),
        .i_y_imm      (y_imm),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_next_pc    (next_pc),
        .o_last_sound (last_sound),
        .o_recovered  (recovered)
    );

    trm_execute_checker #(
        .NUM_REGS (NUM_REGS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_opcode     (opcode),
        .i_x_is_reg   (x_is_reg),
        .i_x_reg      (x_reg),
        .i_x_imm      (x_imm),
        .i_y_is_reg   (y_is_reg),
        .i_y_reg      (y_reg),
        .i_y_imm      (y_imm),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_next_pc    (next_pc),
        .i_last_sound (last_sound),
        .i_recovered  (recovered),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_recoveries (recoveries)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Holds the item until the block takes it; valid stays high across
    // back-to-back items.
    task automatic send_instr(input logic [2:0] op, input logic xr, input logic [IDX_W-1:0] xi,
                              input logic [IMM_W-1:0] xm, input logic yr,
                              input logic [IDX_W-1:0] yi, input logic [IMM_W-1:0] ym);
        int gap;
        if (!calm_tail && tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode   <= op;
        x_is_reg <= xr;
        x_reg    <= xi;
        x_imm    <= xm;
        y_is_reg <= yr;
        y_reg    <= yi;
        y_imm    <= ym;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        op_count[op]++;
        sent++;
    endtask

    function automatic logic [IMM_W-1:0] pick_imm();
        logic [IMM_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = IMM_MIN;
            1: v = IMM_MAX;
            2: v = IMM_NEG1;
            3, 4: v = IMM_W'($urandom_range(0, 16) - 8);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly low registers so instructions feed on each other's results.
    function automatic logic [IDX_W-1:0] pick_reg();
        if ($urandom_range(0, 11) == 0)
            return IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1));
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 4));
        return IDX_W'($urandom_range(0, NUM_REGS - 1));
    endfunction

    initial begin
        logic [2:0] op;
        int         roll;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_SET;
        x_is_reg  = 1'b0;
        x_reg     = '0;
        x_imm     = '0;
        y_is_reg  = 1'b0;
        y_reg     = '0;
        y_imm     = '0;
        cycles    = 0;
        sent      = 0;
        calm_tail = 1'b0;
        tx_gaps   = 1'b1;
        foreach (op_count[k])
            op_count[k] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_instr(OP_SET, 1'b1, REG_A, '0, 1'b0, '0, IMM_MAX);
        send_instr(OP_SET, 1'b1, REG_B, '0, 1'b0, '0, IMM_MIN);
        send_instr(OP_ADD, 1'b1, REG_A, '0, 1'b1, REG_B, '0);
        send_instr(OP_SND, 1'b1, REG_A, '0, 1'b0, '0, '0);
        send_instr(OP_RCV, 1'b1, REG_A, '0, 1'b0, '0, '0);
        send_instr(OP_RCV, 1'b0, '0, '0, 1'b0, '0, '0);
        send_instr(OP_MUL, 1'b1, REG_A, '0, 1'b0, '0, IMM_MIN);
        send_instr(OP_SET, 1'b1, REG_C, '0, 1'b1, REG_A, '0);
        send_instr(OP_MUL, 1'b1, REG_C, '0, 1'b1, REG_C, '0);
        // Doubling 2^62 gives the most negative 64-bit value.
        send_instr(OP_ADD, 1'b1, REG_C, '0, 1'b1, REG_C, '0);
        send_instr(OP_SND, 1'b1, REG_C, '0, 1'b0, '0, '0);
        send_instr(OP_MOD, 1'b1, REG_C, '0, 1'b0, '0, IMM_NEG1);
        send_instr(OP_SET, 1'b1, REG_D, '0, 1'b0, '0, -32'sd7);
        send_instr(OP_MOD, 1'b1, REG_D, '0, 1'b0, '0, 32'd2);
        send_instr(OP_MOD, 1'b1, REG_D, '0, 1'b0, '0, '0);
        send_instr(OP_JGZ, 1'b0, '0, 32'd1, 1'b0, '0, '0);
        send_instr(OP_JGZ, 1'b0, '0, IMM_MAX, 1'b1, REG_B, '0);
        send_instr(OP_JGZ, 1'b1, REG_D, '0, 1'b0, '0, 32'd5);
        send_instr(OP_JGZ, 1'b0, '0, IMM_MIN, 1'b0, '0, 32'd9);
        send_instr(OP_SET, 1'b0, REG_A, IMM_MAX, 1'b0, '0, 32'd3);
        send_instr(OP_MOD, 1'b0, REG_A, IMM_MIN, 1'b0, '0, 32'd3);
        send_instr(OP_SET, 1'b1, REG_TOP, '0, 1'b0, '0, 32'd5);
        send_instr(OP_SND, 1'b1, REG_TOP, '0, 1'b0, '0, '0);
        send_instr(OP_SET, 1'b1, REG_Z, '0, 1'b1, REG_PAST, '0);
        send_instr(OP_NOP, 1'b1, REG_TOP, IMM_NEG1, 1'b1, REG_TOP, IMM_NEG1);
        send_instr(OP_SND, 1'b1, REG_Z, '0, 1'b0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                tx_gaps = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            roll = $urandom_range(0, 19);
            op   = (roll == 19) ? OP_NOP : 3'(roll % 7);
            send_instr(op, $urandom_range(0, 4) != 0, pick_reg(), pick_imm(),
                       1'($urandom_range(0, 1)), pick_reg(), pick_imm());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d instructions (26 directed), compared %0d results, %0d recoveries.",
                 sent, checked, recoveries);
        $display("Mix: set %0d snd %0d rcv %0d add %0d mul %0d mod %0d jgz %0d unassigned %0d.",
                 op_count[OP_SET], op_count[OP_SND], op_count[OP_RCV], op_count[OP_ADD],
                 op_count[OP_MUL], op_count[OP_MOD], op_count[OP_JGZ], op_count[OP_NOP]);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result-side back-pressure: bursts of stalls, with quiet stretches.
    initial begin
        logic rx_stalls;
        int   hold;
        out_ready = 1'b0;
        rx_stalls = 1'b1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                rx_stalls = !rx_stalls;
            if (!calm_tail && rx_stalls && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

endmodule
